// ----- hw/rtl/pidsep_pkg.sv -----
// shared types and constants of the pid controller with integral separation
package pidsep_pkg;

  localparam int unsigned ApbAddrWidth = 6;
  localparam int unsigned ApbDataWidth = 64;

  localparam logic signed [33:0] Q16Deg180 = 34'sd11796480;
  localparam logic signed [33:0] Q16Deg360 = 34'sd23592960;

  typedef enum logic [2:0] {
    REG_GAIN_P           = 3'd0,
    REG_GAIN_I           = 3'd1,
    REG_GAIN_D           = 3'd2,
    REG_ERROR_LIMIT      = 3'd3,
    REG_TERM_LIMITS      = 3'd4,
    REG_DRIVE_LIMIT      = 3'd5,
    REG_ERROR_THRESHOLDS = 3'd6,
    REG_ANGLE_MODE       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [23:0] gain_p;
    logic [23:0] gain_i;
    logic [23:0] gain_d;
    logic [30:0] error_limit;
    logic [47:0] term_limits;
    logic [30:0] drive_limit;
    logic [47:0] error_thresholds;
    logic        angle_mode;
  } cfg_t;

endpackage

// ----- hw/rtl/pidsep_regs.sv -----
// apb configuration register file of the pid controller
module pidsep_regs (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [pidsep_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [pidsep_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [pidsep_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                   pready,
  output pidsep_pkg::cfg_t                       cfg_o
);
  import pidsep_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrWidth-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p           <= '0;
      cfg_q.gain_i           <= '0;
      cfg_q.gain_d           <= '0;
      cfg_q.error_limit      <= '1;
      cfg_q.term_limits      <= '0;
      cfg_q.drive_limit      <= '1;
      cfg_q.error_thresholds <= '0;
      cfg_q.angle_mode       <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:           cfg_q.gain_p           <= pwdata[23:0];
        REG_GAIN_I:           cfg_q.gain_i           <= pwdata[23:0];
        REG_GAIN_D:           cfg_q.gain_d           <= pwdata[23:0];
        REG_ERROR_LIMIT:      cfg_q.error_limit      <= pwdata[30:0];
        REG_TERM_LIMITS:      cfg_q.term_limits      <= pwdata[47:0];
        REG_DRIVE_LIMIT:      cfg_q.drive_limit      <= pwdata[30:0];
        REG_ERROR_THRESHOLDS: cfg_q.error_thresholds <= pwdata[47:0];
        REG_ANGLE_MODE:       cfg_q.angle_mode       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_GAIN_P:           prdata = ApbDataWidth'(cfg_q.gain_p);
      REG_GAIN_I:           prdata = ApbDataWidth'(cfg_q.gain_i);
      REG_GAIN_D:           prdata = ApbDataWidth'(cfg_q.gain_d);
      REG_ERROR_LIMIT:      prdata = ApbDataWidth'(cfg_q.error_limit);
      REG_TERM_LIMITS:      prdata = ApbDataWidth'(cfg_q.term_limits);
      REG_DRIVE_LIMIT:      prdata = ApbDataWidth'(cfg_q.drive_limit);
      REG_ERROR_THRESHOLDS: prdata = ApbDataWidth'(cfg_q.error_thresholds);
      REG_ANGLE_MODE:       prdata = ApbDataWidth'(cfg_q.angle_mode);
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/pidsep_calc.sv -----
// single pass datapath: error wrap and clip, p/i/d terms, drive
module pidsep_calc #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  pidsep_pkg::cfg_t              cfg_i,
  input  logic signed [31:0]            setpoint_i,
  input  logic signed [31:0]            measured_i,
  input  logic signed [31:0]            last_error_i,
  input  logic signed [DATA_WIDTH-1:0]  integral_i,
  output logic signed [31:0]            drive_o,
  output logic signed [31:0]            clipped_error_o,
  output logic signed [DATA_WIDTH-1:0]  integral_o
);
  import pidsep_pkg::*;

  localparam int unsigned MW = 42;
  localparam int unsigned WW = ((DATA_WIDTH > MW) ? DATA_WIDTH : MW) + 3;
  localparam logic signed [WW-1:0] DwMax = WW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [WW-1:0] DwMin = ~DwMax;

  function automatic logic signed [WW-1:0] sat_dw(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v;
    if (v > DwMax) r = DwMax;
    else if (v < DwMin) r = DwMin;
    return r;
  endfunction

  function automatic logic signed [WW-1:0] clip(input logic signed [WW-1:0] v,
                                                input logic [WW-1:0] lim);
    logic signed [WW-1:0] r;
    logic signed [WW-1:0] l;
    l = $signed(lim);
    r = v;
    if (v > l) r = l;
    else if (v < -l) r = -l;
    return r;
  endfunction

  function automatic logic signed [WW-1:0] ext_m(input logic signed [MW-1:0] v);
    return $signed({{(WW-MW){v[MW-1]}}, v});
  endfunction

  logic signed [33:0]      diff;
  logic signed [33:0]      wrapped;
  logic signed [33:0]      err_lim;
  logic signed [31:0]      err;
  logic [31:0]             abs_err;
  logic signed [32:0]      err_x;
  logic signed [32:0]      derr;
  logic signed [57:0]      prod_p;
  logic signed [57:0]      prod_i;
  logic signed [57:0]      prod_d;
  logic signed [WW-1:0]    tp;
  logic signed [WW-1:0]    ti;
  logic signed [WW-1:0]    td;
  logic signed [WW-1:0]    ti_sum;
  logic signed [WW-1:0]    sum;
  logic signed [WW-1:0]    u;
  logic [31:0]             deadband;
  logic [31:0]             gate;
  logic [31:0]             separ;

  assign diff = 34'(setpoint_i) - 34'(measured_i);

  always_comb begin
    wrapped = diff;
    if (cfg_i.angle_mode) begin
      if (diff >= Q16Deg180) wrapped = diff - Q16Deg360;
      else if (diff < -Q16Deg180) wrapped = diff + Q16Deg360;
    end
  end

  assign err_lim = $signed(34'(cfg_i.error_limit));

  always_comb begin
    if (wrapped > err_lim) err = err_lim[31:0];
    else if (wrapped < -err_lim) err = 32'(-err_lim);
    else err = wrapped[31:0];
  end

  assign abs_err = err[31] ? 32'(-err) : 32'(err);
  assign err_x   = 33'(err);
  assign derr    = err_x - 33'(last_error_i);

  assign prod_p = 58'(err_x) * $signed({1'b0, cfg_i.gain_p});
  assign prod_i = 58'(err_x) * $signed({1'b0, cfg_i.gain_i});
  assign prod_d = 58'(derr) * $signed({1'b0, cfg_i.gain_d});

  assign deadband = 32'({cfg_i.error_thresholds[15:0], 8'h00});
  assign gate     = 32'({cfg_i.error_thresholds[31:16], 8'h00});
  assign separ    = 32'({cfg_i.error_thresholds[47:32], 8'h00});

  assign ti_sum = $signed({{(WW-DATA_WIDTH){integral_i[DATA_WIDTH-1]}}, integral_i})
                + sat_dw(ext_m(prod_i[57:16]));

  always_comb begin
    tp = clip(sat_dw(ext_m(prod_p[57:16])), WW'({cfg_i.term_limits[15:0], 16'h0000}));
    ti = clip(sat_dw(ti_sum), WW'({cfg_i.term_limits[31:16], 16'h0000}));
    td = clip(sat_dw(ext_m(prod_d[57:16])), WW'({cfg_i.term_limits[47:32], 16'h0000}));
    if (abs_err > separ) ti = '0;
    if (abs_err <= deadband) tp = '0;
    if (abs_err < gate) begin
      ti = '0;
      td = '0;
    end
  end

  assign sum = tp + ti + td;
  assign u   = clip(sum, WW'(cfg_i.drive_limit));

  assign drive_o         = u[31:0];
  assign clipped_error_o = err;
  assign integral_o      = ti[DATA_WIDTH-1:0];

endmodule

// ----- hw/rtl/pid_integral_separation_angle_wrap.sv -----
// top level of the positional pid controller with integral separation and angle wrap
// Positional PID controller on signed Q16.16 samples. Each transfer of a setpoint and a
// measured value gives one transfer of drive and clipped error. The block sustains one
// sample per clock cycle while the result is not stalled. The input register feeds one
// pass through the error wrap and clip, three parallel gain multipliers and the integral
// accumulate into the result register. A stalled result holds the input register, so the
// input stalls once both registers are full. The integral and previous error state close
// their loop within that single pass, so consecutive samples never wait on each other.
// Registers sit on an APB port at byte address 8*index, are readable, and should be
// written only while no sample is in flight. No clearing pass follows reset.
module pid_integral_separation_angle_wrap #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pidsep_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [pidsep_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [pidsep_pkg::ApbDataWidth-1:0]  prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [31:0]                   setpoint_i,
  input  logic signed [31:0]                   measured_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [31:0]                   drive_o,
  output logic signed [31:0]                   clipped_error_o
);
  import pidsep_pkg::*;

  cfg_t                        cfg;
  logic                        s1_valid_q;
  logic                        s1_valid_d;
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic signed [31:0]          setpoint_q;
  logic signed [31:0]          measured_q;
  logic signed [31:0]          drive_q;
  logic signed [31:0]          clipped_error_q;
  logic signed [31:0]          last_error_q;
  logic signed [DATA_WIDTH-1:0] integral_q;
  logic signed [31:0]          drive_d;
  logic signed [31:0]          clipped_error_d;
  logic signed [DATA_WIDTH-1:0] integral_d;
  logic                        out_adv;
  logic                        s1_adv;
  logic                        in_xfer;

  pidsep_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidsep_calc #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_calc (
    .cfg_i           (cfg),
    .setpoint_i      (setpoint_q),
    .measured_i      (measured_q),
    .last_error_i    (last_error_q),
    .integral_i      (integral_q),
    .drive_o         (drive_d),
    .clipped_error_o (clipped_error_d),
    .integral_o      (integral_d)
  );

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_adv ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      last_error_q <= '0;
      integral_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        last_error_q <= clipped_error_d;
        integral_q   <= integral_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      setpoint_q <= setpoint_i;
      measured_q <= measured_i;
    end
    if (s1_adv) begin
      drive_q         <= drive_d;
      clipped_error_q <= clipped_error_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_q;
  assign clipped_error_o = clipped_error_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_state_matches_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_valid_q && (clipped_error_o == last_error_q)))
    else $error("stored error differs from delivered error");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after transfer");

endmodule

// ----- sim/tb_pid_integral_separation_angle_wrap.sv -----
// testbench of the pid controller with integral separation and angle wrap, with its predictor
package pid_check_pkg;
  import pidsep_pkg::*;

  typedef struct {
    logic signed [31:0] drive;
    logic signed [31:0] err;
  } pid_out_t;

  class pid_drive_predictor;
    bit [23:0]   gain_p, gain_i, gain_d;
    bit [30:0]   err_lim, drv_lim;
    bit [47:0]   term_lim, thresh;
    bit          angle;
    longint      prev_err, integ;
    pid_out_t    pending_drive_q[$];
    int unsigned mismatches;

    function new();
      gain_p     = '0;
      gain_i     = '0;
      gain_d     = '0;
      err_lim    = 31'h7FFF_FFFF;
      drv_lim    = 31'h7FFF_FFFF;
      term_lim   = '0;
      thresh     = '0;
      angle      = 1'b0;
      prev_err   = 0;
      integ      = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [63:0] val);
      case (idx)
        REG_GAIN_P:           gain_p   = val[23:0];
        REG_GAIN_I:           gain_i   = val[23:0];
        REG_GAIN_D:           gain_d   = val[23:0];
        REG_ERROR_LIMIT:      err_lim  = val[30:0];
        REG_TERM_LIMITS:      term_lim = val[47:0];
        REG_DRIVE_LIMIT:      drv_lim  = val[30:0];
        REG_ERROR_THRESHOLDS: thresh   = val[47:0];
        REG_ANGLE_MODE:       angle    = val[0];
        default: ;
      endcase
    endfunction

    static function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // truncating q16.16 product, floor rounding
    static function longint scale(longint v, bit [23:0] g);
      return (v * longint'(g)) >>> 16;
    endfunction

    function void accept_sample(logic signed [31:0] sp, logic signed [31:0] fb);
      longint   e, ae, tp, ti, td, u;
      longint   lim_p, lim_i, lim_d, dead, gate, sep;
      pid_out_t res;
      e     = longint'(sp) - longint'(fb);
      lim_p = longint'(term_lim[15:0]) << 16;
      lim_i = longint'(term_lim[31:16]) << 16;
      lim_d = longint'(term_lim[47:32]) << 16;
      dead  = longint'(thresh[15:0]) << 8;
      gate  = longint'(thresh[31:16]) << 8;
      sep   = longint'(thresh[47:32]) << 8;
      if (angle) begin
        if (e >= longint'(Q16Deg180)) e -= longint'(Q16Deg360);
        else if (e < -longint'(Q16Deg180)) e += longint'(Q16Deg360);
      end
      e  = clip(e, longint'(err_lim));
      ae = (e < 0) ? -e : e;
      tp = clip(sat32(scale(e, gain_p)), lim_p);
      ti = clip(sat32(integ + sat32(scale(e, gain_i))), lim_i);
      if (ae > sep) ti = 0;
      td = clip(sat32(scale(e - prev_err, gain_d)), lim_d);
      if (ae <= dead) tp = 0;
      if (ae < gate) begin
        ti = 0;
        td = 0;
      end
      integ    = ti;
      prev_err = e;
      u        = clip(tp + ti + td, longint'(drv_lim));
      res.drive = u[31:0];
      res.err   = e[31:0];
      pending_drive_q.push_back(res);
    endfunction

    function void check_drive(logic signed [31:0] drive, logic signed [31:0] err);
      pid_out_t exp_r;
      if (pending_drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: drive %0d error %0d", drive, err);
        return;
      end
      exp_r = pending_drive_q.pop_front();
      if (drive !== exp_r.drive || err !== exp_r.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: drive exp %0d got %0d, error exp %0d got %0d",
                   exp_r.drive, drive, exp_r.err, err);
      end
    endfunction

    function int outstanding();
      return pending_drive_q.size();
    endfunction
  endclass
endpackage

module tb_pid_integral_separation_angle_wrap;
  import pidsep_pkg::*;
  import pid_check_pkg::*;

  localparam int unsigned HoldCycles = 150;
  localparam logic signed [31:0] Deg180 = 32'sd11796480;
  localparam logic signed [31:0] SMin = 32'sh8000_0000;
  localparam logic signed [31:0] SMax = 32'sh7FFF_FFFF;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ApbAddrWidth-1:0] paddr = '0;
  logic [ApbDataWidth-1:0] pwdata = '0;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [31:0]      setpoint_i = '0;
  logic signed [31:0]      measured_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [31:0]      drive_o;
  logic signed [31:0]      clipped_error_o;

  pid_drive_predictor pid_model;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_req = 1'b0;

  pid_integral_separation_angle_wrap i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .setpoint_i     (setpoint_i),
    .measured_i     (measured_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .clipped_error_o(clipped_error_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("** pid_integral_separation_angle_wrap: FAILED **");
    $finish;
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      pid_model.check_drive(drive_o, clipped_error_o);
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pid_model.set_reg(idx, val);
  endtask

  task automatic send_item(logic signed [31:0] sp, logic signed [31:0] fb);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    measured_i <= fb;
    do @(posedge clk_i); while (in_stall_o);
    pid_model.accept_sample(sp, fb);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pid_model.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return SMin;
      1:       return SMax;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return Deg180;
      default: return -Deg180;
    endcase
  endfunction

  task automatic send_rand_item();
    logic signed [31:0] sp, fb, d;
    sp = $urandom;
    case ($urandom_range(0, 9))
      0, 1: fb = $urandom;
      2, 3, 4, 5, 6: begin
        // tracking: small error keeps the integral in play
        d  = $signed($urandom) >>> $urandom_range(5, 26);
        fb = sp - d;
      end
      7, 8: begin
        sp = $signed($urandom) >>> 7;
        fb = $signed($urandom) >>> 7;
      end
      default: begin
        sp = corner_value();
        fb = corner_value();
      end
    endcase
    send_item(sp, fb);
  endtask

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return 24'd0;
      1:       return 24'($urandom_range(0, 24'h01FFFF));
      2:       return 24'($urandom_range(0, 24'h00FFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 31'h7FFF_FFFF;
      1:       return 31'($urandom_range(1, 32'h00C8_0000));
      2:       return 31'($urandom);
      3:       return 31'($urandom_range(0, 65535));
      default: return 31'($urandom_range(32'h0010_0000, 32'h0400_0000));
    endcase
  endfunction

  function automatic logic [15:0] pick_term_limit();
    case ($urandom_range(0, 5))
      0:       return 16'hFFFF;
      1:       return 16'd0;
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  task automatic write_rand_config();
    logic [63:0] v;
    v = {$urandom, $urandom}; v[23:0] = pick_gain(); write_reg(REG_GAIN_P, v);
    v = {$urandom, $urandom}; v[23:0] = pick_gain(); write_reg(REG_GAIN_I, v);
    v = {$urandom, $urandom}; v[23:0] = pick_gain(); write_reg(REG_GAIN_D, v);
    v = {$urandom, $urandom}; v[30:0] = pick_limit(); write_reg(REG_ERROR_LIMIT, v);
    v = {$urandom, $urandom};
    v[47:0] = {pick_term_limit(), pick_term_limit(), pick_term_limit()};
    write_reg(REG_TERM_LIMITS, v);
    v = {$urandom, $urandom}; v[30:0] = pick_limit(); write_reg(REG_DRIVE_LIMIT, v);
    v = {$urandom, $urandom};
    v[15:0]  = 16'($urandom_range(0, 16'h0300));
    v[31:16] = 16'($urandom_range(0, 16'h0600));
    v[47:32] = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'h3000));
    write_reg(REG_ERROR_THRESHOLDS, v);
    write_reg(REG_ANGLE_MODE, {$urandom, $urandom});
  endtask

  initial begin
    int ph;
    pid_model = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    repeat (8) send_rand_item();
    drain();

    // directed: wrap edges, deadband, gate and separation borders
    write_reg(REG_GAIN_P, 64'h0001_8000);
    write_reg(REG_GAIN_I, 64'h0000_4000);
    write_reg(REG_GAIN_D, 64'h0002_0000);
    write_reg(REG_ERROR_LIMIT, 64'h7FFF_FFFF);
    write_reg(REG_TERM_LIMITS, 64'h07D0_01F4_03E8);
    write_reg(REG_DRIVE_LIMIT, 64'h7FFF_FFFF);
    write_reg(REG_ERROR_THRESHOLDS, 64'h1000_0200_0100);
    write_reg(REG_ANGLE_MODE, 64'd1);
    send_item(32'sd0, 32'sd0);
    send_item(SMax, SMin);
    send_item(SMin, SMax);
    send_item(SMax, SMax);
    send_item(Deg180, 32'sd0);
    send_item(Deg180 - 32'sd1, 32'sd0);
    send_item(-Deg180, 32'sd0);
    send_item(-Deg180 - 32'sd1, 32'sd0);
    send_item(32'sd65536, 32'sd0);
    send_item(32'sd65537, 32'sd0);
    send_item(32'sd131072, 32'sd0);
    send_item(32'sd131071, 32'sd0);
    repeat (4) send_item(32'sd327680, 32'sd0);
    send_item(32'sd1048576, 32'sd0);
    send_item(32'sd1048577, 32'sd0);
    send_item(32'sd327680, 32'sd0);
    send_item(-32'sd327680, 32'sd0);
    send_item(32'sd0, SMin);
    drain();

    // gains, limits and separation threshold at their largest, every term active
    write_reg(REG_GAIN_P, 64'hFF_FFFF);
    write_reg(REG_GAIN_I, 64'hFF_FFFF);
    write_reg(REG_GAIN_D, 64'hFF_FFFF);
    write_reg(REG_ERROR_LIMIT, 64'h7FFF_FFFF);
    write_reg(REG_TERM_LIMITS, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_DRIVE_LIMIT, 64'h7FFF_FFFF);
    write_reg(REG_ERROR_THRESHOLDS, 64'hFFFF_0000_0000);
    write_reg(REG_ANGLE_MODE, 64'd0);
    repeat (12) send_rand_item();
    drain();

    // zero limits force everything to zero
    write_reg(REG_ERROR_LIMIT, 64'd0);
    write_reg(REG_TERM_LIMITS, 64'd0);
    write_reg(REG_DRIVE_LIMIT, 64'd0);
    write_reg(REG_ERROR_THRESHOLDS, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_ANGLE_MODE, 64'd1);
    repeat (8) send_rand_item();
    drain();

    for (ph = 0; ph < 8; ph++) begin
      write_rand_config();
      src_idle  = (ph < 7) && ($urandom_range(0, 3) != 0);
      sink_idle = (ph < 7) && ($urandom_range(0, 3) != 0);
      if (ph == 2) begin
        src_idle = 1'b0;
        hold_req = 1'b1;
      end
      repeat (66) send_rand_item();
      drain();
    end

    if (pid_model.mismatches == 0) begin
      $display("** pid_integral_separation_angle_wrap: PASSED **");
    end else begin
      $display("** pid_integral_separation_angle_wrap: FAILED **");
    end
    $finish;
  end

endmodule
